@@ rtl/four_way_equal_power_crossfade_mixer_defines.svh @@
// assertion macros for the four-way crossfade mixer checker
`ifndef FOUR_WAY_EQUAL_POWER_CROSSFADE_MIXER_DEFINES_SVH
`define FOUR_WAY_EQUAL_POWER_CROSSFADE_MIXER_DEFINES_SVH

// same-cycle implication, muted during reset
`define FWX_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fwx check failed");

// next-cycle implication, muted during reset
`define FWX_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fwx check failed");

// next-cycle implication that also holds across reset
`define FWX_ASSERT_RESET(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("fwx reset check failed");

`endif

@@ rtl/fwx_pkg.sv @@
// types and constants shared by the four-way crossfade mixer files
package fwx_pkg;

  // sample format
  localparam int SAMPLE_WIDTH = 24;

  // configuration register format
  localparam int CFG_WIDTH   = 17;
  localparam int POS_WIDTH   = 18;
  localparam int POS_FRAC    = 16;
  localparam int LEVEL_FRAC  = 14;
  localparam int NUM_INPUTS  = 4;

  localparam logic [CFG_WIDTH-1:0] FADE_MAX    = 17'd65536;
  localparam logic [CFG_WIDTH-1:0] LEVEL_MAX   = 17'd65536;
  localparam logic [CFG_WIDTH-1:0] FADE_RESET  = 17'd0;
  localparam logic [CFG_WIDTH-1:0] LEVEL_RESET = 17'd16384;
  localparam logic [POS_WIDTH-1:0] POS_ONE     = 18'd65536;

  // saturation rails
  localparam logic signed [SAMPLE_WIDTH-1:0] SMP_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SMP_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  // register indexes
  typedef enum logic [0:0] {
    REG_FADE_POSITION = 1'b0,
    REG_OUTPUT_LEVEL  = 1'b1
  } fwx_reg_t;

  // input word: one frame of four samples
  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample_one;
    logic signed [SAMPLE_WIDTH-1:0] sample_two;
    logic signed [SAMPLE_WIDTH-1:0] sample_three;
    logic signed [SAMPLE_WIDTH-1:0] sample_four;
  } fwx_in_t;

  // output word
  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] mixed_sample;
    logic                           clipped;
  } fwx_out_t;

endpackage

@@ rtl/four_way_equal_power_crossfade_mixer.sv @@
// four-way equal-power crossfade mixer: gain pipeline and six-stage sample pipeline
//
// Usage:
//   in_valid/in_ready/in_data carry one frame of four signed samples per word.
//   out_valid/out_ready/out_data carry the saturated mix and a clip flag.
//   cfg_we/cfg_index/cfg_wdata write fade_position (Q1.16) and output_level
//   (Q3.14); writes load the registers at once, with no handshake and no read-back.
// Timing:
//   one word per cycle sustained while out_ready is high and no gain settle is
//   under way; an accepted frame passes six pipeline registers, the last is the output.
//   The window gains are worked out from the registers by a free-running
//   pipeline: a clamp/scale stage, a window stage and four square-root stages
//   of ceil((GAIN_FRAC_BITS+1)/4) digit steps each.
//   After reset, and after every configuration write, in_ready stays low while
//   that gain pipeline settles.
// Reset and stalls:
//   reset empties the pipeline and loads fade 0 and level 1.0.
//   every stage holds a valid bit; when out_ready is low, words pile up in the
//   empty stages first, and back-pressure drops in_ready only when all six are full.
module four_way_equal_power_crossfade_mixer #(
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  fwx_pkg::fwx_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output fwx_pkg::fwx_out_t                   out_data,
  input  logic                                cfg_we,
  input  fwx_pkg::fwx_reg_t                   cfg_index,
  input  logic [fwx_pkg::CFG_WIDTH-1:0]       cfg_wdata
);

  localparam int SW       = fwx_pkg::SAMPLE_WIDTH;
  localparam int CW       = fwx_pkg::CFG_WIDTH;
  localparam int PW       = fwx_pkg::POS_WIDTH;
  localparam int NIN      = fwx_pkg::NUM_INPUTS;
  localparam int F        = GAIN_FRAC_BITS;
  localparam int GAIN_W   = F + 1;
  // square root: SQ_TOT digits (GAIN_W rounded up to a multiple of SQ_STAGES) spread over SQ_STAGES stages
  localparam int SQ_STAGES = 4;
  localparam int SQ_PER    = (GAIN_W + SQ_STAGES - 1) / SQ_STAGES;
  localparam int SQ_TOT    = SQ_PER * SQ_STAGES;
  localparam int XPAD_W    = 2 * SQ_TOT;
  localparam int REM_W     = SQ_TOT + 3;
  localparam int SQ_SHIFT  = 2 * F - 16;
  // settle time of the gain pipeline after a register change
  localparam int GAIN_DEPTH = SQ_STAGES + 2;
  localparam int SETTLE     = GAIN_DEPTH - 1;
  localparam int SETTLE_W   = $clog2(SETTLE + 1);
  // datapath widths
  localparam int PROD_W  = SW + GAIN_W + 1;
  localparam int PAIR_W  = PROD_W + 1;
  localparam int ACC_W   = PAIR_W + 1;
  localparam int Q_W     = ACC_W - F;
  localparam int A_W     = Q_W + CW + 1;
  localparam int RL_W    = F + CW;
  localparam int LOW_W   = F + fwx_pkg::LEVEL_FRAC + 4;
  localparam int CARRY_W = LOW_W - F - fwx_pkg::LEVEL_FRAC;
  localparam int RES_W   = A_W - fwx_pkg::LEVEL_FRAC + 1;
  localparam int NSTG    = 6;
  localparam logic [LOW_W-1:0] ROUND = LOW_W'(1) << (F + fwx_pkg::LEVEL_FRAC - 1);

  // configuration registers
  logic [CW-1:0]       fade_r;
  logic [CW-1:0]       level_r;
  logic [SETTLE_W-1:0] settle_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fade_r   <= fwx_pkg::FADE_RESET;
      level_r  <= fwx_pkg::LEVEL_RESET;
      settle_r <= SETTLE_W'(SETTLE);
    end else if (cfg_we) begin
      settle_r <= SETTLE_W'(SETTLE);
      unique case (cfg_index)
        fwx_pkg::REG_FADE_POSITION: begin
          fade_r <= cfg_wdata;
        end
        fwx_pkg::REG_OUTPUT_LEVEL: begin
          level_r <= cfg_wdata;
        end
      endcase
    end else if (settle_r != '0) begin
      settle_r <= settle_r - SETTLE_W'(1);
    end
  end

  // gain pipe stage 0: clamp fade and level, scale fade by three
  logic [PW-1:0] pos_r;
  logic [CW-1:0] level_c_r;
  logic [CW-1:0] fade_c;

  assign fade_c = (fade_r > fwx_pkg::FADE_MAX) ? fwx_pkg::FADE_MAX : fade_r;

  always_ff @(posedge clk) begin
    pos_r     <= {fade_c, 1'b0} + PW'(fade_c);
    level_c_r <= (level_r > fwx_pkg::LEVEL_MAX) ? fwx_pkg::LEVEL_MAX : level_r;
  end

  // square-root stage registers, index 0 is loaded from the window stage
  logic [XPAD_W-1:0] sq_x_r    [SQ_STAGES][NIN];
  logic [REM_W-1:0]  sq_rem_r  [SQ_STAGES][NIN];
  logic [SQ_TOT-1:0] sq_root_r [SQ_STAGES][NIN];
  logic [GAIN_W-1:0] gain_r    [NIN];

  // gain pipe stage 1: triangular window per input
  for (genvar k = 0; k < NIN; k++) begin : g_win
    localparam logic [PW-1:0] CENTRE = PW'(k) << fwx_pkg::POS_FRAC;
    logic signed [PW:0] diff;
    logic [PW-1:0]      delta;
    logic [CW-1:0]      lin;

    always_comb begin
      diff  = $signed({1'b0, pos_r}) - $signed({1'b0, CENTRE});
      delta = diff[PW] ? PW'(-diff) : diff[PW-1:0];
      lin   = (delta >= fwx_pkg::POS_ONE) ? '0 : CW'(fwx_pkg::POS_ONE - delta);
    end

    always_ff @(posedge clk) begin
      sq_x_r[0][k]    <= XPAD_W'(lin) << SQ_SHIFT;
      sq_rem_r[0][k]  <= '0;
      sq_root_r[0][k] <= '0;
    end
  end

  // gain pipe stages 2..: digit-by-digit square root, SQ_PER digits a stage
  for (genvar s = 0; s < SQ_STAGES; s++) begin : g_sq
    for (genvar k = 0; k < NIN; k++) begin : g_lane
      logic [XPAD_W-1:0] x_nxt;
      logic [REM_W-1:0]  rem_nxt;
      logic [REM_W-1:0]  trial;
      logic [SQ_TOT-1:0] root_nxt;

      always_comb begin
        x_nxt    = sq_x_r[s][k];
        rem_nxt  = sq_rem_r[s][k];
        root_nxt = sq_root_r[s][k];
        trial    = '0;
        for (int j = 0; j < SQ_PER; j++) begin
          rem_nxt = {rem_nxt[REM_W-3:0], x_nxt[XPAD_W-1 -: 2]};
          x_nxt   = {x_nxt[XPAD_W-3:0], 2'b00};
          trial   = {1'b0, root_nxt, 2'b01};
          if (rem_nxt >= trial) begin
            rem_nxt  = rem_nxt - trial;
            root_nxt = {root_nxt[SQ_TOT-2:0], 1'b1};
          end else begin
            root_nxt = {root_nxt[SQ_TOT-2:0], 1'b0};
          end
        end
      end

      if (s < SQ_STAGES - 1) begin : g_mid
        always_ff @(posedge clk) begin
          sq_x_r[s+1][k]    <= x_nxt;
          sq_rem_r[s+1][k]  <= rem_nxt;
          sq_root_r[s+1][k] <= root_nxt;
        end
      end else begin : g_last
        always_ff @(posedge clk) begin
          gain_r[k] <= root_nxt[GAIN_W-1:0];
        end
      end
    end
  end

  // sample pipeline handshake: valid per stage, ready ripples back
  logic [NSTG-1:0] stg_v_r;
  logic [NSTG-1:0] stg_rdy;

  always_comb begin
    stg_rdy[NSTG-1] = !stg_v_r[NSTG-1] || out_ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      stg_rdy[i] = !stg_v_r[i] || stg_rdy[i+1];
    end
  end

  assign in_ready = stg_rdy[0] && (settle_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= '0;
    end else begin
      if (stg_rdy[0]) begin
        stg_v_r[0] <= in_valid && in_ready;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (stg_rdy[i]) begin
          stg_v_r[i] <= stg_v_r[i-1];
        end
      end
    end
  end

  // stage 0: input word
  fwx_pkg::fwx_in_t s0_data_r;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_data_r <= in_data;
    end
  end

  // stage 1: sample times root gain
  logic signed [SW-1:0]     smp      [NIN];
  logic signed [PROD_W-1:0] prod_nxt [NIN];
  logic signed [PROD_W-1:0] prod_r   [NIN];

  assign smp[0] = s0_data_r.sample_one;
  assign smp[1] = s0_data_r.sample_two;
  assign smp[2] = s0_data_r.sample_three;
  assign smp[3] = s0_data_r.sample_four;

  for (genvar k = 0; k < NIN; k++) begin : g_mul
    assign prod_nxt[k] = PROD_W'(smp[k]) * PROD_W'($signed({1'b0, gain_r[k]}));

    always_ff @(posedge clk) begin
      if (stg_rdy[1]) begin
        prod_r[k] <= prod_nxt[k];
      end
    end
  end

  // stages 2 and 3: adder tree
  logic signed [PAIR_W-1:0] pair_r [2];
  logic signed [ACC_W-1:0]  acc_r;

  always_ff @(posedge clk) begin
    if (stg_rdy[2]) begin
      pair_r[0] <= PAIR_W'(prod_r[0]) + PAIR_W'(prod_r[1]);
      pair_r[1] <= PAIR_W'(prod_r[2]) + PAIR_W'(prod_r[3]);
    end
    if (stg_rdy[3]) begin
      acc_r <= ACC_W'(pair_r[0]) + ACC_W'(pair_r[1]);
    end
  end

  // stage 4: level multiply, split into integer and fraction parts
  logic signed [Q_W-1:0] acc_q;
  logic [F-1:0]          acc_f;
  logic signed [A_W-1:0] a_nxt;
  logic [RL_W-1:0]       rl_nxt;
  logic signed [A_W-1:0] a_r;
  logic [RL_W-1:0]       rl_r;

  assign acc_q  = $signed(acc_r[ACC_W-1:F]);
  assign acc_f  = acc_r[F-1:0];
  assign a_nxt  = A_W'(acc_q) * A_W'($signed({1'b0, level_c_r}));
  assign rl_nxt = RL_W'(acc_f) * RL_W'(level_c_r);

  always_ff @(posedge clk) begin
    if (stg_rdy[4]) begin
      a_r  <= a_nxt;
      rl_r <= rl_nxt;
    end
  end

  // stage 5: round half up, recombine and saturate into the output register
  logic [LOW_W-1:0]         low;
  logic [CARRY_W-1:0]       carry;
  logic signed [RES_W-1:0]  res;
  logic                     over_hi;
  logic                     over_lo;
  fwx_pkg::fwx_out_t        out_nxt;
  fwx_pkg::fwx_out_t        out_data_r;

  always_comb begin
    low   = LOW_W'({a_r[fwx_pkg::LEVEL_FRAC-1:0], {F{1'b0}}}) + LOW_W'(rl_r) + ROUND;
    carry = low[LOW_W-1 -: CARRY_W];
    res   = RES_W'($signed(a_r[A_W-1:fwx_pkg::LEVEL_FRAC])) + RES_W'(carry);
    over_hi = !res[RES_W-1] && (|res[RES_W-2:SW-1]);
    over_lo = res[RES_W-1] && !(&res[RES_W-2:SW-1]);
    out_nxt.clipped = over_hi || over_lo;
    if (over_hi) begin
      out_nxt.mixed_sample = fwx_pkg::SMP_MAX;
    end else if (over_lo) begin
      out_nxt.mixed_sample = fwx_pkg::SMP_MIN;
    end else begin
      out_nxt.mixed_sample = res[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (stg_rdy[5]) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = stg_v_r[NSTG-1];
  assign out_data  = out_data_r;

endmodule

@@ rtl/fwx_checker.sv @@
// port-level checker for the four-way crossfade mixer, bound to the top level
`include "four_way_equal_power_crossfade_mixer_defines.svh"

module fwx_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input fwx_pkg::fwx_out_t out_data,
  input logic              cfg_we
);

  // output sample sits on either rail
  logic on_rail;

  assign on_rail = (out_data.mixed_sample == fwx_pkg::SMP_MAX) ||
                   (out_data.mixed_sample == fwx_pkg::SMP_MIN);

  // a stalled output word stays and holds its payload
  `FWX_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `FWX_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_data))

  // a register write closes the input while the gains settle
  `FWX_ASSERT_NEXT(a_cfg_settle, cfg_we, !in_ready)

  // a clipped word sits on one of the rails
  `FWX_ASSERT_NOW(a_clip_rail, out_valid && out_data.clipped, on_rail)

  // reset empties the output and closes the input
  `FWX_ASSERT_RESET(a_reset_idle, !rst_n, !out_valid && !in_ready)

endmodule

bind four_way_equal_power_crossfade_mixer fwx_checker u_fwx_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .cfg_we    (cfg_we)
);

@@ tb/testbench.sv @@
// self-checking testbench for the four-way equal-power crossfade mixer
module testbench;

  localparam int GAIN_BITS  = 16;
  localparam int TOP        = int'(fwx_pkg::SMP_MAX);
  localparam int BOT        = int'(fwx_pkg::SMP_MIN);
  localparam int FRAMES_PER = 384;
  localparam int RETUNE_GAP = 48;
  localparam int SW         = fwx_pkg::SAMPLE_WIDTH;
  localparam int CW         = fwx_pkg::CFG_WIDTH;

  // one row of the directed plan: a register write or a frame
  typedef struct {
    bit                  write;
    fwx_pkg::fwx_reg_t   index;
    logic [CW-1:0]       setting;
    fwx_pkg::fwx_in_t    frame;
    bit                  known;
    fwx_pkg::fwx_out_t   want;
  } plan_row_t;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  fwx_pkg::fwx_in_t     in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  fwx_pkg::fwx_out_t    out_data;
  logic                 cfg_we    = 1'b0;
  fwx_pkg::fwx_reg_t    cfg_index = fwx_pkg::REG_FADE_POSITION;
  logic [CW-1:0]        cfg_wdata = '0;

  // register copies seen by the mix predictor
  logic [CW-1:0] fade_reg  = fwx_pkg::FADE_RESET;
  logic [CW-1:0] level_reg = fwx_pkg::LEVEL_RESET;

  fwx_pkg::fwx_out_t pending_mix [$];
  int                errors      = 0;
  int                tx_idle_pct = 0;
  int                rx_idle_pct = 0;

  four_way_equal_power_crossfade_mixer #(
    .GAIN_FRAC_BITS(GAIN_BITS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit, far beyond the slowest correct run
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  // floor of the square root, bit by bit from the top
  function automatic longint unsigned floor_root(longint unsigned x);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 23; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= x) r = t;
    end
    return r;
  endfunction

  // triangular window per input, square-root gain, level, round half up, saturate
  function automatic fwx_pkg::fwx_out_t mix_frame(fwx_pkg::fwx_in_t f);
    longint            fade, level, pos, span, delta, lin, gain, acc, res;
    longint            smp [fwx_pkg::NUM_INPUTS];
    fwx_pkg::fwx_out_t r;
    fade   = longint'((fade_reg > fwx_pkg::FADE_MAX) ? fwx_pkg::FADE_MAX : fade_reg);
    level  = longint'((level_reg > fwx_pkg::LEVEL_MAX) ? fwx_pkg::LEVEL_MAX : level_reg);
    span   = longint'(fwx_pkg::POS_ONE);
    pos    = fade * 3;
    smp[0] = longint'(f.sample_one);
    smp[1] = longint'(f.sample_two);
    smp[2] = longint'(f.sample_three);
    smp[3] = longint'(f.sample_four);
    acc    = 0;
    for (int k = 0; k < fwx_pkg::NUM_INPUTS; k++) begin
      delta = pos - k * span;
      if (delta < 0) delta = -delta;
      if (delta > span) delta = span;
      lin  = span - delta;
      gain = floor_root(lin << (2 * GAIN_BITS - fwx_pkg::POS_FRAC));
      acc += smp[k] * gain;
    end
    res = (acc * level + (longint'(1) << (GAIN_BITS + fwx_pkg::LEVEL_FRAC - 1)))
          >>> (GAIN_BITS + fwx_pkg::LEVEL_FRAC);
    r.clipped = 1'b0;
    if (res > TOP) begin
      res       = TOP;
      r.clipped = 1'b1;
    end else if (res < BOT) begin
      res       = BOT;
      r.clipped = 1'b1;
    end
    r.mixed_sample = res[SW-1:0];
    return r;
  endfunction

  function automatic fwx_pkg::fwx_in_t frame_of(int a, int b, int c, int d);
    fwx_pkg::fwx_in_t f;
    f.sample_one   = a[SW-1:0];
    f.sample_two   = b[SW-1:0];
    f.sample_three = c[SW-1:0];
    f.sample_four  = d[SW-1:0];
    return f;
  endfunction

  function automatic plan_row_t reg_row(fwx_pkg::fwx_reg_t idx, int v);
    plan_row_t p;
    p = '{write: 1'b1, index: idx, setting: v[CW-1:0], default: '0};
    return p;
  endfunction

  function automatic plan_row_t open_row(int a, int b, int c, int d);
    plan_row_t p;
    p = '{index: fwx_pkg::REG_FADE_POSITION, frame: frame_of(a, b, c, d), default: '0};
    return p;
  endfunction

  function automatic plan_row_t known_row(int a, int b, int c, int d, int m, bit clip);
    plan_row_t p;
    p                   = open_row(a, b, c, d);
    p.known             = 1'b1;
    p.want.mixed_sample = m[SW-1:0];
    p.want.clipped      = clip;
    return p;
  endfunction

  // random sample: rails, values near zero, or anything
  function automatic logic [SW-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return fwx_pkg::SMP_MAX;
      1:       return fwx_pkg::SMP_MIN;
      2:       return SW'($urandom_range(512) - 256);
      default: return SW'($urandom);
    endcase
  endfunction

  function automatic fwx_pkg::fwx_in_t pick_frame();
    fwx_pkg::fwx_in_t f;
    logic [SW-1:0]    s;
    if ($urandom_range(7) == 0) begin
      s = pick_sample();
      f = {s, s, s, s};
    end else begin
      f = {pick_sample(), pick_sample(), pick_sample(), pick_sample()};
    end
    return f;
  endfunction

  // random register value: zero, full scale, above full scale, a typical value, or any value up to full scale
  function automatic logic [CW-1:0] pick_setting(logic [CW-1:0] typical);
    case ($urandom_range(5))
      0:       return '0;
      1:       return fwx_pkg::FADE_MAX;
      2:       return CW'($urandom_range(131071, 65537));
      3:       return typical;
      default: return CW'($urandom_range(65536));
    endcase
  endfunction

  // hold the input side until every expected word has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_mix.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(fwx_pkg::fwx_reg_t idx, logic [CW-1:0] v);
    drain();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      fwx_pkg::REG_FADE_POSITION: fade_reg  = v;
      fwx_pkg::REG_OUTPUT_LEVEL:  level_reg = v;
      default: ;
    endcase
  endtask

  // send one frame, with a random gap first, and queue its expected word
  task automatic push_frame(fwx_pkg::fwx_in_t f, bit known, fwx_pkg::fwx_out_t want);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= f;
    do @(posedge clk); while (!in_ready);
    pending_mix.push_back(known ? want : mix_frame(f));
  endtask

  task automatic check_result(fwx_pkg::fwx_out_t got);
    fwx_pkg::fwx_out_t want;
    if (pending_mix.size() == 0) begin
      errors++;
      $display("%0t: unexpected word, got mixed_sample %0d clipped %0b",
               $time, got.mixed_sample, got.clipped);
    end else begin
      want = pending_mix.pop_front();
      if (got.mixed_sample !== want.mixed_sample) begin
        errors++;
        $display("%0t: mixed_sample mismatch, expected %0d, got %0d",
                 $time, want.mixed_sample, got.mixed_sample);
      end
      if (got.clipped !== want.clipped) begin
        errors++;
        $display("%0t: clipped mismatch, expected %0b, got %0b",
                 $time, want.clipped, got.clipped);
      end
    end
  endtask

  // output side: check accepted words, stall at random
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_result(out_data);
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  initial begin
    plan_row_t         plan [$];
    fwx_pkg::fwx_out_t none;
    none = '0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset state: fade 0 and unity level pass sample_one straight through
    plan.push_back(known_row(TOP, BOT, BOT, BOT, TOP, 1'b0));
    plan.push_back(known_row(BOT, TOP, TOP, TOP, BOT, 1'b0));
    plan.push_back(known_row(0, TOP, BOT, -1, 0, 1'b0));
    plan.push_back(known_row(-1, 0, 0, 0, -1, 1'b0));
    plan.push_back(known_row(1, -1, -1, -1, 1, 1'b0));
    // level 4.0: overflow saturates both ways
    plan.push_back(reg_row(fwx_pkg::REG_OUTPUT_LEVEL, 65536));
    plan.push_back(known_row(TOP, 0, 0, 0, TOP, 1'b1));
    plan.push_back(known_row(BOT, 0, 0, 0, BOT, 1'b1));
    plan.push_back(known_row(2097151, TOP, TOP, TOP, 8388604, 1'b0));
    plan.push_back(known_row(2097152, TOP, TOP, TOP, TOP, 1'b1));
    // level above four is held at four
    plan.push_back(reg_row(fwx_pkg::REG_OUTPUT_LEVEL, 131071));
    plan.push_back(known_row(2097152, 0, 0, 0, TOP, 1'b1));
    plan.push_back(known_row(-2097152, 0, 0, 0, BOT, 1'b0));
    // level zero mutes everything
    plan.push_back(reg_row(fwx_pkg::REG_OUTPUT_LEVEL, 0));
    plan.push_back(known_row(TOP, TOP, TOP, TOP, 0, 1'b0));
    // full fade selects sample_four, fade above one is held at one
    plan.push_back(reg_row(fwx_pkg::REG_OUTPUT_LEVEL, 16384));
    plan.push_back(reg_row(fwx_pkg::REG_FADE_POSITION, 65536));
    plan.push_back(known_row(BOT, BOT, BOT, 12345, 12345, 1'b0));
    plan.push_back(reg_row(fwx_pkg::REG_FADE_POSITION, 131071));
    plan.push_back(known_row(0, 0, 0, -777, -777, 1'b0));
    // fade positions between inputs
    plan.push_back(reg_row(fwx_pkg::REG_FADE_POSITION, 32768));
    plan.push_back(open_row(TOP, TOP, TOP, TOP));
    plan.push_back(open_row(BOT, BOT, BOT, BOT));
    plan.push_back(reg_row(fwx_pkg::REG_FADE_POSITION, 21845));
    plan.push_back(open_row(1000, 2000, 3000, 4000));
    plan.push_back(reg_row(fwx_pkg::REG_FADE_POSITION, 43691));
    plan.push_back(open_row(-5, 7, -9, 11));
    plan.push_back(reg_row(fwx_pkg::REG_FADE_POSITION, 1));
    plan.push_back(open_row(TOP, TOP, 0, 0));
    plan.push_back(reg_row(fwx_pkg::REG_OUTPUT_LEVEL, 65536));
    plan.push_back(reg_row(fwx_pkg::REG_FADE_POSITION, 65535));
    plan.push_back(open_row(0, 0, TOP, BOT));
    plan.push_back(open_row(123456, -654321, 3, -3));

    foreach (plan[i]) begin
      if (plan[i].write) write_reg(plan[i].index, plan[i].setting);
      else push_frame(plan[i].frame, plan[i].known, plan[i].want);
    end

    // random frames: mostly receiver stalls, then mostly sender gaps, then full rate
    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 84 : 0;
      rx_idle_pct = (phase == 0) ? 84 : (phase == 1) ? 31 : 0;
      for (int n = 0; n < FRAMES_PER; n++) begin
        if (n % RETUNE_GAP == 0) begin
          if ($urandom_range(1)) begin
            write_reg(fwx_pkg::REG_FADE_POSITION, pick_setting(17'd32768));
            write_reg(fwx_pkg::REG_OUTPUT_LEVEL, pick_setting(fwx_pkg::LEVEL_RESET));
          end else begin
            write_reg(fwx_pkg::REG_OUTPUT_LEVEL, pick_setting(fwx_pkg::LEVEL_RESET));
            write_reg(fwx_pkg::REG_FADE_POSITION, pick_setting(17'd32768));
          end
        end
        push_frame(pick_frame(), 1'b0, none);
      end
    end

    drain();
    rx_idle_pct = 0;
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
